[hdl/double_ended_queue_unit_macros.svh]
// Assertion macros for the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/deq_pkg.sv]
// Shared types and constants of the double-ended queue.
package deq_pkg;

  localparam int WORD_W = 32;
  localparam int OP_W   = 3;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [OP_W-1:0]   op_t;

  localparam op_t OP_PUSH_BACK  = 3'd0;
  localparam op_t OP_PUSH_FRONT = 3'd1;
  localparam op_t OP_POP_BACK   = 3'd2;
  localparam op_t OP_POP_FRONT  = 3'd3;
  localparam op_t OP_CLEAR      = 3'd4;

  // Reported for an empty end and for a pop that finds nothing.
  localparam word_t EMPTY_WORD = '1;

endpackage

[hdl/deq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/double_ended_queue_unit.sv]
// Top level of the double-ended queue: ring buffer in RAM with cached end words.
//
//  channel  direction  fields (low bit first)
//  s_*      in         tuser: op[2:0]; tdata: data_in[31:0]
//  m_*      out        tuser: error; tdata: value_out, count, front_value, back_value
//
// Push, clear, error and idle-code results are registered directly; a pop
// leaving the queue non-empty first waits in ST_READ for the registered RAM read
// of the new end word. Input is taken only outside ST_READ, when the result
// register is free or drains in the same cycle, so a stalled m_tready holds off
// the input side. Reset (rst, synchronous) empties the queue; RAM is not cleared.
`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [31:0]         s_tdata,  // data_in[31:0]
  input  logic [2:0]          s_tuser,  // op[2:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [((3 * deq_pkg::WORD_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
                              m_tdata,  // value_out, count, front_value, back_value
  output logic [0:0]          m_tuser   // error
);

  localparam int PW       = $clog2(DEPTH);
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int OUT_BITS = 3 * deq_pkg::WORD_W + CW;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // control states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
    ring_prev = (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
  endfunction

  // queue state
  logic [PW-1:0]         head, head_next;
  logic [PW-1:0]         tail, tail_next;
  logic [CW-1:0]         count, count_next;
  deq_pkg::word_t        front_word, front_word_next;
  deq_pkg::word_t        back_word, back_word_next;
  logic                  state, state_next;
  logic                  pend_front, pend_front_next;

  // result register
  logic                  out_valid, out_valid_next;
  deq_pkg::word_t        value, value_next;
  logic                  error, error_next;

  // RAM port
  logic                  ram_we;
  logic [PW-1:0]         ram_waddr;
  logic                  ram_re;
  logic [PW-1:0]         ram_raddr;
  deq_pkg::word_t        ram_rdata;

  logic                  accept;
  logic                  is_empty;
  logic                  is_full;
  deq_pkg::op_t          op;
  deq_pkg::word_t        data_in;
  deq_pkg::word_t        front_field;
  deq_pkg::word_t        back_field;

  assign op       = s_tuser;
  assign data_in  = s_tdata;
  assign is_empty = (count == '0);
  assign is_full  = (count == CW'(DEPTH));
  assign s_tready = (state == ST_IDLE) && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;

  deq_ram #(
    .WIDTH (deq_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (data_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    front_word_next = front_word;
    back_word_next  = back_word;
    state_next      = state;
    pend_front_next = pend_front;
    value_next      = value;
    error_next      = error;
    out_valid_next  = out_valid && !m_tready;
    ram_we          = 1'b0;
    ram_waddr       = tail;
    ram_re          = 1'b0;
    ram_raddr       = head;

    if (state == ST_READ) begin
      // new end word arrives from RAM; result is marked valid
      if (pend_front) begin
        front_word_next = ram_rdata;
      end else begin
        back_word_next = ram_rdata;
      end
      state_next     = ST_IDLE;
      out_valid_next = 1'b1;
    end else if (accept) begin
      value_next     = '0;
      error_next     = 1'b0;
      out_valid_next = 1'b1;
      unique case (op)
        deq_pkg::OP_PUSH_BACK: begin
          if (is_full) begin
            error_next = 1'b1;
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = tail;
            tail_next      = ring_next(tail);
            count_next     = count + 1'b1;
            back_word_next = data_in;
            if (is_empty) begin
              front_word_next = data_in;
            end
          end
        end
        deq_pkg::OP_PUSH_FRONT: begin
          if (is_full) begin
            error_next = 1'b1;
          end else begin
            ram_we          = 1'b1;
            ram_waddr       = ring_prev(head);
            head_next       = ring_prev(head);
            count_next      = count + 1'b1;
            front_word_next = data_in;
            if (is_empty) begin
              back_word_next = data_in;
            end
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (is_empty) begin
            value_next = deq_pkg::EMPTY_WORD;
            error_next = 1'b1;
          end else begin
            value_next = back_word;
            tail_next  = ring_prev(tail);
            count_next = count - 1'b1;
            if (count != CW'(1)) begin
              // fetch the word that becomes the new back
              ram_re          = 1'b1;
              ram_raddr       = ring_prev(ring_prev(tail));
              pend_front_next = 1'b0;
              state_next      = ST_READ;
              out_valid_next  = 1'b0;
            end
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (is_empty) begin
            value_next = deq_pkg::EMPTY_WORD;
            error_next = 1'b1;
          end else begin
            value_next = front_word;
            head_next  = ring_next(head);
            count_next = count - 1'b1;
            if (count != CW'(1)) begin
              ram_re          = 1'b1;
              ram_raddr       = ring_next(head);
              pend_front_next = 1'b1;
              state_next      = ST_READ;
              out_valid_next  = 1'b0;
            end
          end
        end
        deq_pkg::OP_CLEAR: begin
          head_next  = '0;
          tail_next  = '0;
          count_next = '0;
        end
        default: begin
          // unused codes report the state unchanged
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    front_word <= front_word_next;
    back_word  <= back_word_next;
    pend_front <= pend_front_next;
    value      <= value_next;
    error      <= error_next;
  end

  // Queue state only moves on an accepted transfer or a RAM read, so it holds
  // while the result waits and the end fields can be formed from it directly.
  assign front_field = is_empty ? deq_pkg::EMPTY_WORD : front_word;
  assign back_field  = is_empty ? deq_pkg::EMPTY_WORD : back_word;

  assign m_tvalid = out_valid;
  assign m_tuser  = error;
  assign m_tdata  = OUT_W'({back_field, front_field, count, value});

  // ring consistency: tail sits count places past head
  logic [CW:0] ptr_sum;
  logic [CW:0] tail_expect;
  assign ptr_sum     = (CW + 1)'(head) + (CW + 1)'(count);
  assign tail_expect = (ptr_sum >= (CW + 1)'(DEPTH)) ? ptr_sum - (CW + 1)'(DEPTH) : ptr_sum;

  `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH), "count above depth")
  `DEQ_ASSERT_NOW(a_ring_ptrs, 1'b1, tail == PW'(tail_expect), "tail and head out of step")
  `DEQ_ASSERT_NOW(a_read_no_result, state == ST_READ, !out_valid, "result held during read")
  `DEQ_ASSERT_NEXT(a_read_one_cycle, state == ST_READ, state == ST_IDLE && out_valid, "read stuck")

endmodule

[sim/double_ended_queue_checker.sv]
// Checker for the double-ended queue: tracks the ring state and compares each result transfer.
module double_ended_queue_checker #(
  parameter int DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [31:0]  s_tdata,   // data_in[31:0]
  input  logic [2:0]   s_tuser,   // op[2:0]
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,   // value_out, count, front_value, back_value, pad
  input  logic [0:0]   m_tuser,   // error
  output int           fail_count,
  output int           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PTR_W = $clog2(DEPTH);

  typedef struct packed {
    deq_pkg::word_t value;
    logic           error;
    logic [4:0]     count;
    deq_pkg::word_t front;
    deq_pkg::word_t back;
  } deq_result_t;

  deq_pkg::word_t    ring [DEPTH];
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  int unsigned       fill;
  deq_result_t       expected_results [$];
  deq_result_t       want;
  int                fails = 0;

  function automatic logic [PTR_W-1:0] ring_up(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_down(logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  // Applies one operation to the shadow ring and returns the result it should give.
  function automatic deq_result_t deque_apply(deq_pkg::op_t op, deq_pkg::word_t data);
    deq_result_t r;
    r = '0;
    case (op)
      deq_pkg::OP_PUSH_BACK: begin
        if (fill == DEPTH) begin
          r.error = 1'b1;
        end else begin
          ring[tail] = data;
          tail = ring_up(tail);
          fill++;
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        if (fill == DEPTH) begin
          r.error = 1'b1;
        end else begin
          head = ring_down(head);
          ring[head] = data;
          fill++;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (fill == 0) begin
          r.value = deq_pkg::EMPTY_WORD;
          r.error = 1'b1;
        end else begin
          tail = ring_down(tail);
          r.value = ring[tail];
          fill--;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (fill == 0) begin
          r.value = deq_pkg::EMPTY_WORD;
          r.error = 1'b1;
        end else begin
          r.value = ring[head];
          head = ring_up(head);
          fill--;
        end
      end
      deq_pkg::OP_CLEAR: begin
        head = '0;
        tail = '0;
        fill = 0;
      end
      default: ;  // spare codes leave the state alone
    endcase
    r.count = 5'(fill);
    if (fill == 0) begin
      r.front = deq_pkg::EMPTY_WORD;
      r.back  = deq_pkg::EMPTY_WORD;
    end else begin
      r.front = ring[head];
      r.back  = ring[ring_down(tail)];
    end
    return r;
  endfunction

  function automatic int field_differs(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      head = '0;
      tail = '0;
      fill = 0;
      expected_results.delete();
    end else begin
      // result side first: a result never belongs to the input taken at the same edge
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no operation outstanding");
          fails++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          fails += field_differs("value_out", want.value, m_tdata[31:0]);
          fails += field_differs("error", 32'(want.error), 32'(m_tuser[0]));
          fails += field_differs("count", 32'(want.count), 32'(m_tdata[36:32]));
          fails += field_differs("front_value", want.front, m_tdata[68:37]);
          fails += field_differs("back_value", want.back, m_tdata[100:69]);
        end
      end
      if (s_tvalid && s_tready)
        expected_results.insert(expected_results.size(),
          deque_apply(deq_pkg::op_t'(s_tuser), deq_pkg::word_t'(s_tdata)));
    end
    fail_count  <= fails;
    outstanding <= expected_results.size();
  end

endmodule

[sim/double_ended_queue_unit_tb.sv]
// Testbench top for the double-ended queue: stimulus, stalls, watchdog and verdict.
module double_ended_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS   = 1450;
  localparam int CALM_TAIL     = 150;   // phases starting in the last transfers run with no idling
  localparam int STALL_LIMIT   = 1000;  // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES  = 10;    // extra cycles waited after the last result

  // Codes the block treats as no-ops.
  localparam deq_pkg::op_t OP_SPARE_LO  = 3'd5;
  localparam deq_pkg::op_t OP_SPARE_MID = 3'd6;
  localparam deq_pkg::op_t OP_SPARE_HI  = 3'd7;

  typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIX} stim_mode_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;       // data_in[31:0]
  logic [2:0]   s_tuser = '0;       // op[2:0]
  logic         m_tvalid;
  logic         m_tready = 1'b1;
  logic [103:0] m_tdata;            // value_out, count, front_value, back_value, pad
  logic [0:0]   m_tuser;            // error

  int fail_count;
  int outstanding;
  int quiet_cycles = 0;
  bit gaps_on = 1'b0;               // enables idle bursts on both sides
  int sent = 0;

  double_ended_queue_unit #(.DEPTH(16)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  double_ended_queue_checker #(.DEPTH(16)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result-side back-pressure: random stall bursts while gaps are enabled.
  initial begin
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Watchdog: any transfer on either side resets the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Mostly random words, with the extremes and all-ones/all-zeros mixed in.
  function automatic deq_pkg::word_t pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return deq_pkg::word_t'($urandom);
    endcase
  endfunction

  // Fill mode drives the ring to full, drain mode to empty; clears and spare codes are rare.
  function automatic deq_pkg::op_t pick_op(stim_mode_t mode);
    int roll;
    int push_pct;
    roll = $urandom_range(0, 99);
    push_pct = (mode == MODE_FILL) ? 78 : (mode == MODE_DRAIN) ? 18 : 47;
    if (roll < 2)
      return deq_pkg::OP_CLEAR;
    if (roll < 5)
      return deq_pkg::op_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    if (roll < 5 + push_pct)
      return $urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
    return $urandom_range(0, 1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
  endfunction

  // One input transfer, optionally preceded by an idle burst.
  task automatic send(deq_pkg::op_t op, deq_pkg::word_t data);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  initial begin
    stim_mode_t mode;
    int         phase_len;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty pops, last-element pops from both ends, field extremes, spare codes, clear.
    send(deq_pkg::OP_POP_BACK, pick_word());
    send(deq_pkg::OP_POP_FRONT, pick_word());
    send(deq_pkg::OP_PUSH_BACK, 32'h8000_0000);
    send(deq_pkg::OP_POP_FRONT, pick_word());
    send(deq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff);
    send(deq_pkg::OP_POP_BACK, pick_word());
    send(deq_pkg::OP_PUSH_BACK, 32'h0000_0000);
    send(deq_pkg::OP_PUSH_FRONT, 32'hffff_ffff);
    send(deq_pkg::OP_PUSH_BACK, 32'h5555_5555);
    send(deq_pkg::OP_PUSH_FRONT, 32'haaaa_aaaa);
    send(OP_SPARE_LO, 32'h0000_0000);
    send(OP_SPARE_MID, 32'hffff_ffff);
    send(OP_SPARE_HI, 32'hdead_beef);
    send(deq_pkg::OP_POP_BACK, pick_word());
    send(deq_pkg::OP_POP_FRONT, pick_word());
    send(deq_pkg::OP_CLEAR, 32'hffff_ffff);
    send(deq_pkg::OP_POP_FRONT, pick_word());
    send(deq_pkg::OP_PUSH_FRONT, 32'h1234_5678);  // head wraps below slot zero
    send(deq_pkg::OP_POP_BACK, pick_word());

    // Random phases; fill and drain phases push the ring against both bounds.
    while (sent < TOTAL_ITEMS) begin
      mode      = stim_mode_t'($urandom_range(0, 2));
      phase_len = $urandom_range(30, 80);
      gaps_on   = (TOTAL_ITEMS - sent > CALM_TAIL) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < phase_len && sent < TOTAL_ITEMS; i++)
        send(pick_op(mode), pick_word());
    end

    s_tvalid <= 1'b0;
    gaps_on = 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
